// ===== hw/rtl/ksde_pkg.sv =====
// ============================================================================
// ksde_pkg - key scan debounce and events, shared definitions
// Widths, key positions, reset values, the front-to-back record, the result
// record, bit reversal and the preset colour table.
// ============================================================================
package ksde_pkg;

  // field widths
  localparam int unsigned SCAN_W   = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned NOTE_W   = 27;
  localparam int unsigned PRESET_W = 3;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned THRESH_W = 16;

  // default geometry
  localparam int unsigned HISTORY_DEPTH_DEF = 8;
  localparam int unsigned NOTE_KEYS_DEF     = 27;
  localparam int unsigned QUEUE_DEPTH       = 4;

  // special key positions in the debounced word
  localparam int unsigned KEY_PAGE   = 27;
  localparam int unsigned KEY_LFO    = 28;
  localparam int unsigned KEY_ARP    = 29;
  localparam int unsigned KEY_PRESET = 30;

  // reset values
  localparam logic [SCAN_W-1:0]   KEYS_IDLE       = '1;
  localparam logic [THRESH_W-1:0] LONG_PRESS_RST  = 16'd400;

  // record handed from the front to the back
  typedef struct packed {
    logic [SCAN_W-1:0] keys;
    logic [NOTE_W-1:0] note_down;
    logic [NOTE_W-1:0] note_up;
    logic              page;
    logic              lfo_tgl;
    logic              arp_tgl;
    logic              preset_down;
    logic              preset_up;
    logic [TIME_W-1:0] now_ms;
  } evt_rec_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // one result beat
  typedef struct packed {
    logic [SCAN_W-1:0]   keys;
    logic [NOTE_W-1:0]   note_down;
    logic [NOTE_W-1:0]   note_up;
    logic                page;
    logic                lfo_on;
    logic                arp_on;
    logic [PRESET_W-1:0] preset;
    logic                short_press;
    logic                long_held;
    rgb_t                rgb;
  } result_t;

  // mux position i lands on bit SCAN_W-1-i
  function automatic logic [SCAN_W-1:0] bit_reverse(input logic [SCAN_W-1:0] v);
    logic [SCAN_W-1:0] r;
    for (int i = 0; i < SCAN_W; i++) begin
      r[i] = v[SCAN_W-1-i];
    end
    return r;
  endfunction

  // preset colour lookup
  function automatic rgb_t preset_color(input logic [PRESET_W-1:0] p);
    rgb_t c;
    case (p)
      3'd0:    c = '{8'd255, 8'd0,   8'd0};
      3'd1:    c = '{8'd74,  8'd0,   8'd181};
      3'd2:    c = '{8'd255, 8'd0,   8'd35};
      3'd3:    c = '{8'd0,   8'd115, 8'd150};
      3'd4:    c = '{8'd10,  8'd0,   8'd255};
      3'd5:    c = '{8'd255, 8'd39,  8'd0};
      3'd6:    c = '{8'd15,  8'd255, 8'd0};
      3'd7:    c = '{8'd255, 8'd100, 8'd90};
      default: c = '{8'd255, 8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/ksde_front.sv =====
// ============================================================================
// ksde_front - scan history ring, debounce and edge classification
// Keeps the last HISTORY_DEPTH scan words, takes the reversed word as the
// debounced state when the ring is uniform and classifies key edges.
// ============================================================================
module ksde_front #(
  parameter int unsigned HISTORY_DEPTH = ksde_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned NOTE_KEYS     = ksde_pkg::NOTE_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ksde_pkg::SCAN_W-1:0] raw_scan,
  input  logic [ksde_pkg::TIME_W-1:0] now_ms,
  output ksde_pkg::evt_rec_t          rec
);

  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  logic [ksde_pkg::SCAN_W-1:0] hist_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0]           slot_r;
  logic [SLOT_W-1:0]           slot_nxt;
  logic [ksde_pkg::SCAN_W-1:0] keys_r;
  logic [ksde_pkg::SCAN_W-1:0] keys_nxt;
  logic [ksde_pkg::SCAN_W-1:0] word;
  logic                        uniform;
  logic [ksde_pkg::NOTE_W-1:0] note_en;
  logic [ksde_pkg::SCAN_W-1:0] fell;
  logic [ksde_pkg::SCAN_W-1:0] rose;

  // bit 0 is a spare mux position, held released
  assign word = raw_scan | ksde_pkg::SCAN_W'(1);

  // ring is uniform when every other entry matches the word being written
  always_comb begin
    uniform = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if ((SLOT_W'(i) != slot_r) && (hist_r[i] != word)) begin
        uniform = 1'b0;
      end
    end
  end

  assign keys_nxt = uniform ? ksde_pkg::bit_reverse(word) : keys_r;
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);

  // note keys at and above NOTE_KEYS are masked off
  always_comb begin
    for (int i = 0; i < ksde_pkg::NOTE_W; i++) begin
      note_en[i] = (i < NOTE_KEYS);
    end
  end

  // active low: a falling bit is a press, a rising bit a release
  assign fell = ~keys_nxt & keys_r;
  assign rose = keys_nxt & ~keys_r;

  always_comb begin
    rec.keys        = keys_nxt;
    rec.note_down   = fell[ksde_pkg::NOTE_W-1:0] & note_en;
    rec.note_up     = rose[ksde_pkg::NOTE_W-1:0] & note_en;
    rec.page        = fell[ksde_pkg::KEY_PAGE];
    rec.lfo_tgl     = fell[ksde_pkg::KEY_LFO];
    rec.arp_tgl     = fell[ksde_pkg::KEY_ARP];
    rec.preset_down = fell[ksde_pkg::KEY_PRESET];
    rec.preset_up   = rose[ksde_pkg::KEY_PRESET];
    rec.now_ms      = now_ms;
  end

  // history ring and debounced state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= ksde_pkg::KEYS_IDLE;
      end
      slot_r <= '0;
      keys_r <= ksde_pkg::KEYS_IDLE;
    end else if (accept) begin
      hist_r[slot_r] <= word;
      slot_r         <= slot_nxt;
      keys_r         <= keys_nxt;
    end
  end

endmodule

// ===== hw/rtl/ksde_queue.sv =====
// ============================================================================
// ksde_queue - small register queue
// Decouples the front from the back; first in, first out.
// ============================================================================
module ksde_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ksde_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ksde_back.sv =====
// ============================================================================
// ksde_back - toggle flags, preset press timing and result register
// Applies one classified record per cycle, while the result is free or popped,
// to the flag and preset state and holds the result beat until it is popped.
// ============================================================================
module ksde_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ksde_pkg::evt_rec_t            rec,
  input  logic                          rec_valid,
  output logic                          rec_take,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ksde_pkg::THRESH_W-1:0] cfg_long_press_ms,
  output ksde_pkg::result_t             res,
  output logic                          res_valid,
  input  logic                          res_pop
);

  logic                          out_valid_r;
  ksde_pkg::result_t             res_r;
  ksde_pkg::result_t             res_nxt;
  logic [ksde_pkg::THRESH_W-1:0] hold_thresh_r;
  logic                          lfo_r;
  logic                          arp_r;
  logic [ksde_pkg::PRESET_W-1:0] preset_r;
  logic [ksde_pkg::PRESET_W-1:0] preset_nxt;
  logic [ksde_pkg::TIME_W-1:0]   press_start_r;
  logic [ksde_pkg::TIME_W-1:0]   dur;
  logic [ksde_pkg::TIME_W-1:0]   thresh;
  logic                          short_p;
  logic                          long_p;

  assign cfg_ready = 1'b1;
  assign res       = res_r;
  assign res_valid = out_valid_r;

  // take a record when the result register is free or being popped
  assign rec_take = rec_valid && (!out_valid_r || res_pop);

  // press duration, modulo 2^32
  assign dur     = rec.now_ms - press_start_r;
  assign thresh  = ksde_pkg::TIME_W'(hold_thresh_r);
  assign short_p = rec.preset_up && (dur < thresh);
  assign long_p  = rec.preset_up && (dur > thresh);
  assign preset_nxt = short_p ? preset_r + ksde_pkg::PRESET_W'(1) : preset_r;

  // next result beat
  always_comb begin
    res_nxt.keys        = rec.keys;
    res_nxt.note_down   = rec.note_down;
    res_nxt.note_up     = rec.note_up;
    res_nxt.page        = rec.page;
    res_nxt.lfo_on      = lfo_r ^ rec.lfo_tgl;
    res_nxt.arp_on      = arp_r ^ rec.arp_tgl;
    res_nxt.preset      = preset_nxt;
    res_nxt.short_press = short_p;
    res_nxt.long_held   = long_p;
    res_nxt.rgb         = ksde_pkg::preset_color(preset_nxt);
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rec_take) begin
      res_r <= res_nxt;
    end
  end

  // control state, flags and threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      hold_thresh_r <= ksde_pkg::LONG_PRESS_RST;
      lfo_r         <= 1'b0;
      arp_r         <= 1'b0;
      preset_r      <= '0;
      press_start_r <= '0;
    end else begin
      if (cfg_valid) begin
        hold_thresh_r <= cfg_long_press_ms;
      end
      if (rec_take) begin
        out_valid_r <= 1'b1;
        lfo_r       <= res_nxt.lfo_on;
        arp_r       <= res_nxt.arp_on;
        preset_r    <= preset_nxt;
        if (rec.preset_down) begin
          press_start_r <= rec.now_ms;
        end
      end else if (res_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/key_scan_debounce_events.sv =====
// ============================================================================
// key_scan_debounce_events - key matrix debounce and key event decoder
// History-ring debounce of a 32-bit active-low scan word, key edge masks,
// LFO/ARP toggles, timed preset key with colour lookup.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   in_      | input     | push / full          | raw_scan, now_ms
//   out_     | output    | empty / pop          | debounced keys, masks, flags,
//            |           |                      | preset, press pulses, rgb
//   cfg_     | input     | cfg_valid/cfg_ready  | long_press_ms
//
// One beat in and one beat out per cycle when neither side stalls; a beat
// reaches the result ports through the front logic, the queue and then the
// back result register, and waits there until popped. Reset is synchronous
// and takes no clearing pass: control state resets at once, data does not.
// A stalled result side fills the queue between front and back; full rises
// once QUEUE_DEPTH beats wait behind the held result. cfg_ready is always high.
// ============================================================================
module key_scan_debounce_events #(
  parameter int unsigned HISTORY_DEPTH = ksde_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned NOTE_KEYS     = ksde_pkg::NOTE_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  logic [ksde_pkg::SCAN_W-1:0]   in_raw_scan,
  input  logic [ksde_pkg::TIME_W-1:0]   in_now_ms,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic [ksde_pkg::SCAN_W-1:0]   out_debounced_keys,
  output logic [ksde_pkg::NOTE_W-1:0]   out_note_down_mask,
  output logic [ksde_pkg::NOTE_W-1:0]   out_note_up_mask,
  output logic                          out_page_pressed,
  output logic                          out_lfo_on,
  output logic                          out_arp_on,
  output logic [ksde_pkg::PRESET_W-1:0] out_preset_index,
  output logic                          out_short_press,
  output logic                          out_long_press_seen,
  output logic [ksde_pkg::COLOR_W-1:0]  out_red,
  output logic [ksde_pkg::COLOR_W-1:0]  out_green,
  output logic [ksde_pkg::COLOR_W-1:0]  out_blue,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ksde_pkg::THRESH_W-1:0] cfg_long_press_ms
);

  localparam int unsigned REC_W = $bits(ksde_pkg::evt_rec_t);

  ksde_pkg::evt_rec_t front_rec;
  ksde_pkg::evt_rec_t back_rec;
  ksde_pkg::result_t  res;
  logic [REC_W-1:0]   q_rdata;
  logic               in_accept;
  logic               q_empty;
  logic               rec_take;
  logic               res_valid;

  assign in_accept = push && !full;

  // front: history ring and edge classification
  ksde_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .NOTE_KEYS     (NOTE_KEYS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .raw_scan (in_raw_scan),
    .now_ms   (in_now_ms),
    .rec      (front_rec)
  );

  // decoupling queue
  ksde_queue #(
    .WIDTH (REC_W),
    .DEPTH (ksde_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .wdata (front_rec),
    .full  (full),
    .pop   (rec_take),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign back_rec = ksde_pkg::evt_rec_t'(q_rdata);

  // back: flags, preset timing, result register
  ksde_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec               (back_rec),
    .rec_valid         (!q_empty),
    .rec_take          (rec_take),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_long_press_ms (cfg_long_press_ms),
    .res               (res),
    .res_valid         (res_valid),
    .res_pop           (pop)
  );

  // result ports
  assign empty               = !res_valid;
  assign out_debounced_keys  = res.keys;
  assign out_note_down_mask  = res.note_down;
  assign out_note_up_mask    = res.note_up;
  assign out_page_pressed    = res.page;
  assign out_lfo_on          = res.lfo_on;
  assign out_arp_on          = res.arp_on;
  assign out_preset_index    = res.preset;
  assign out_short_press     = res.short_press;
  assign out_long_press_seen = res.long_held;
  assign out_red             = res.rgb.red;
  assign out_green           = res.rgb.green;
  assign out_blue            = res.rgb.blue;

  // no result beat right after a reset cycle
  a_empty_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> empty)
    else $error("result beat present right after reset");

  // a key cannot be pressed and released in the same beat
  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_note_down_mask & out_note_up_mask) == '0))
    else $error("note key both pressed and released in one beat");

  // a preset release is never both short and long
  a_press_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_short_press && out_long_press_seen))
    else $error("short and long press in one beat");

endmodule

// ===== bench/ksde_event_check.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ksde_event_check - result checker for the key scan debounce block
// Watches the scan, result and threshold channels at the rising edge, keeps
// its own debounce ring and key state, predicts one result beat per scan
// beat and compares every field of each popped beat with the oldest one due.
// ============================================================================
module ksde_event_check (
  input  logic                          clk,
  input  logic                          rst_n,
  // scan channel
  input  logic                          push,
  input  logic                          full,
  input  logic [ksde_pkg::SCAN_W-1:0]   in_raw_scan,
  input  logic [ksde_pkg::TIME_W-1:0]   in_now_ms,
  // result channel
  input  logic                          empty,
  input  logic                          pop,
  input  logic [ksde_pkg::SCAN_W-1:0]   out_debounced_keys,
  input  logic [ksde_pkg::NOTE_W-1:0]   out_note_down_mask,
  input  logic [ksde_pkg::NOTE_W-1:0]   out_note_up_mask,
  input  logic                          out_page_pressed,
  input  logic                          out_lfo_on,
  input  logic                          out_arp_on,
  input  logic [ksde_pkg::PRESET_W-1:0] out_preset_index,
  input  logic                          out_short_press,
  input  logic                          out_long_press_seen,
  input  logic [ksde_pkg::COLOR_W-1:0]  out_red,
  input  logic [ksde_pkg::COLOR_W-1:0]  out_green,
  input  logic [ksde_pkg::COLOR_W-1:0]  out_blue,
  // threshold channel
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ksde_pkg::THRESH_W-1:0] cfg_long_press_ms,
  // to the top
  output int                            mismatches,
  output int                            pending
);
  import ksde_pkg::*;

  localparam int unsigned RING = HISTORY_DEPTH_DEF;
  localparam int unsigned MAX_PRINTED = 40;

  // preset colours, preset 0 in the low 24 bits, each entry {red, green, blue}
  localparam logic [8*24-1:0] RGB_TABLE = {
    24'hFF645A, 24'h0FFF00, 24'hFF2700, 24'h0A00FF,
    24'h007396, 24'hFF0023, 24'h4A00B5, 24'hFF0000
  };

  // own copy of the block state
  logic [SCAN_W-1:0]   ring_words [RING];
  int unsigned         ring_slot;
  logic [SCAN_W-1:0]   stable_keys;
  logic [SCAN_W-1:0]   last_keys;
  logic                lfo_st;
  logic                arp_st;
  logic [PRESET_W-1:0] preset;
  logic [TIME_W-1:0]   press_start;
  logic [THRESH_W-1:0] long_ms;

  result_t due_results [$];
  result_t want;
  int      beat_no;

  initial begin
    mismatches = 0;
    pending    = 0;
    beat_no    = 0;
  end

  // mux position i lands on bit 31-i
  function automatic logic [SCAN_W-1:0] mirror(input logic [SCAN_W-1:0] w);
    logic [SCAN_W-1:0] m;
    for (int b = 0; b < SCAN_W; b++) m[SCAN_W-1-b] = w[b];
    return m;
  endfunction

  // one scan beat through the ring, edge detection and preset timing
  function automatic result_t scan_to_events(input logic [SCAN_W-1:0] raw,
                                             input logic [TIME_W-1:0] stamp);
    result_t           r;
    logic              settled;
    logic [SCAN_W-1:0] fell;
    logic [SCAN_W-1:0] rose;
    logic [TIME_W-1:0] held_ms;
    logic [23:0]       rgb;
    ring_words[ring_slot] = raw | 32'h1;
    ring_slot = (ring_slot == RING - 1) ? 0 : ring_slot + 1;
    settled = 1'b1;
    for (int i = 1; i < RING; i++)
      if (ring_words[i] != ring_words[0]) settled = 1'b0;
    if (settled) stable_keys = mirror(ring_words[0]);

    // active low: a press is a high-to-low change
    fell = ~stable_keys & last_keys;
    rose = stable_keys & ~last_keys;
    r = '0;
    r.keys      = stable_keys;
    r.note_down = fell[NOTE_W-1:0];
    r.note_up   = rose[NOTE_W-1:0];
    r.page      = fell[KEY_PAGE];
    if (fell[KEY_LFO]) lfo_st = ~lfo_st;
    if (fell[KEY_ARP]) arp_st = ~arp_st;
    if (fell[KEY_PRESET]) press_start = stamp;
    if (rose[KEY_PRESET]) begin
      // duration wraps with the millisecond counter
      held_ms = stamp - press_start;
      if (held_ms < {16'h0, long_ms}) begin
        r.short_press = 1'b1;
        preset = preset + 1'b1;
      end
      if (held_ms > {16'h0, long_ms}) r.long_held = 1'b1;
    end
    r.lfo_on = lfo_st;
    r.arp_on = arp_st;
    r.preset = preset;
    rgb = RGB_TABLE[preset*24 +: 24];
    r.rgb.red   = rgb[23:16];
    r.rgb.green = rgb[15:8];
    r.rgb.blue  = rgb[7:0];
    last_keys = stable_keys;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: result beat %0d, %s: got %h, predicted %h",
               $time, beat_no, what, seen, wanted);
  endtask

  task automatic check_field(input string what, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted) report_mismatch(what, seen, wanted);
  endtask

  // sample all three channels at the edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING; i++) ring_words[i] = KEYS_IDLE;
      ring_slot   = 0;
      stable_keys = KEYS_IDLE;
      last_keys   = KEYS_IDLE;
      lfo_st      = 1'b0;
      arp_st      = 1'b0;
      preset      = '0;
      press_start = '0;
      long_ms     = LONG_PRESS_RST;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) long_ms = cfg_long_press_ms;
      if (push && !full) due_results.push_back(scan_to_events(in_raw_scan, in_now_ms));
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_mismatch("beat with no prediction due", out_debounced_keys, '0);
        end else begin
          want = due_results.pop_front();
          check_field("debounced_keys", out_debounced_keys, want.keys);
          check_field("note_down_mask", 32'(out_note_down_mask), 32'(want.note_down));
          check_field("note_up_mask", 32'(out_note_up_mask), 32'(want.note_up));
          check_field("page_pressed", 32'(out_page_pressed), 32'(want.page));
          check_field("lfo_on", 32'(out_lfo_on), 32'(want.lfo_on));
          check_field("arp_on", 32'(out_arp_on), 32'(want.arp_on));
          check_field("preset_index", 32'(out_preset_index), 32'(want.preset));
          check_field("short_press", 32'(out_short_press), 32'(want.short_press));
          check_field("long_press_seen", 32'(out_long_press_seen),
                      32'(want.long_held));
          check_field("red", 32'(out_red), 32'(want.rgb.red));
          check_field("green", 32'(out_green), 32'(want.rgb.green));
          check_field("blue", 32'(out_blue), 32'(want.rgb.blue));
        end
        beat_no++;
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench top for key_scan_debounce_events
// Drives scan beats (held key words long enough to settle the debounce ring,
// with broken runs and noise in between), drains results with random stalls
// and one long hold-off, steps the long-press threshold through several
// values between phases and gives the verdict from the checker's count.
// ============================================================================
module tb_top;
  import ksde_pkg::*;

  localparam int STALL_LIMIT = 1000;
  // raw scan bit positions of the special keys (the word is mirrored)
  localparam int PRESET_RAW_BIT = SCAN_W - 1 - KEY_PRESET;
  localparam int PAGE_RAW_BIT   = SCAN_W - 1 - KEY_PAGE;

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [SCAN_W-1:0]   in_raw_scan;
  logic [TIME_W-1:0]   in_now_ms;
  logic                empty;
  logic                pop;
  logic [SCAN_W-1:0]   out_debounced_keys;
  logic [NOTE_W-1:0]   out_note_down_mask;
  logic [NOTE_W-1:0]   out_note_up_mask;
  logic                out_page_pressed;
  logic                out_lfo_on;
  logic                out_arp_on;
  logic [PRESET_W-1:0] out_preset_index;
  logic                out_short_press;
  logic                out_long_press_seen;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_long_press_ms;

  int mismatches;
  int pending;
  int pop_beats;
  int stall_cycles;

  // stimulus view of the keys: last settled word, press time, threshold
  logic [SCAN_W-1:0] held_raw;
  logic [TIME_W-1:0] press_ms;
  logic [TIME_W-1:0] thr;
  logic              calm;

  key_scan_debounce_events dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_raw_scan         (in_raw_scan),
    .in_now_ms           (in_now_ms),
    .empty               (empty),
    .pop                 (pop),
    .out_debounced_keys  (out_debounced_keys),
    .out_note_down_mask  (out_note_down_mask),
    .out_note_up_mask    (out_note_up_mask),
    .out_page_pressed    (out_page_pressed),
    .out_lfo_on          (out_lfo_on),
    .out_arp_on          (out_arp_on),
    .out_preset_index    (out_preset_index),
    .out_short_press     (out_short_press),
    .out_long_press_seen (out_long_press_seen),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_long_press_ms   (cfg_long_press_ms)
  );

  ksde_event_check event_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_raw_scan         (in_raw_scan),
    .in_now_ms           (in_now_ms),
    .empty               (empty),
    .pop                 (pop),
    .out_debounced_keys  (out_debounced_keys),
    .out_note_down_mask  (out_note_down_mask),
    .out_note_up_mask    (out_note_up_mask),
    .out_page_pressed    (out_page_pressed),
    .out_lfo_on          (out_lfo_on),
    .out_arp_on          (out_arp_on),
    .out_preset_index    (out_preset_index),
    .out_short_press     (out_short_press),
    .out_long_press_seen (out_long_press_seen),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_long_press_ms   (cfg_long_press_ms),
    .mismatches          (mismatches),
    .pending             (pending)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // popped result beats, used to time the long hold-off
  initial pop_beats = 0;
  always @(posedge clk) begin
    if (rst_n && pop && !empty) pop_beats++;
  end

  // result side: random stall bursts, one long hold-off that fills the block
  initial begin : result_side
    int  hold;
    bit  squeezed;
    hold     = 0;
    squeezed = 0;
    pop      = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!squeezed && pop_beats >= 250) begin
        squeezed = 1;
        hold     = 90;
      end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving anywhere
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // one scan beat, called just after a falling edge, returns just after a falling edge once the beat is accepted
  task automatic send_scan(input logic [SCAN_W-1:0] raw, input logic [TIME_W-1:0] stamp);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    push        <= 1'b1;
    in_raw_scan <= raw;
    in_now_ms   <= stamp;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // threshold write once every predicted result has come back
  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_long_press_ms <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    thr = {16'h0, value};
  endtask

  // runs of one held word, broken runs and noise beats
  task automatic play_phase(input int budget);
    int                sent;
    int                kind;
    int                run_len;
    logic [SCAN_W-1:0] word;
    logic [SCAN_W-1:0] flips;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] span;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // settled run: flip a random set of keys of the held word
        case ($urandom_range(0, 5))
          0:       flips = 32'h1 << $urandom_range(0, 31);
          1:       flips = $urandom & $urandom & $urandom;
          2:       flips = 32'h1 << PRESET_RAW_BIT;
          3:       flips = 32'h1 << $urandom_range(PRESET_RAW_BIT, PAGE_RAW_BIT);
          4:       flips = $urandom;
          default: flips = (32'h1 << PRESET_RAW_BIT) | (32'h1 << $urandom_range(5, 31));
        endcase
        word    = held_raw ^ flips;
        run_len = $urandom_range(8, 13);
      end else begin
        word    = $urandom;
        run_len = (kind == 9) ? 1 : $urandom_range(2, 7);
      end
      for (int k = 1; k <= run_len; k++) begin
        stamp = $urandom;
        // the eighth beat settles the ring: aim the press duration at the threshold
        if (kind <= 6 && k == 8) begin
          case ($urandom_range(0, 5))
            0:       span = thr - 1;
            1:       span = thr;
            2:       span = thr + 1;
            3, 4:    span = $urandom_range(0, thr);
            default: span = $urandom;
          endcase
          stamp = press_ms + span;
          if (held_raw[PRESET_RAW_BIT] && !word[PRESET_RAW_BIT]) press_ms = stamp;
        end
        send_scan(word, stamp);
      end
      if (kind <= 6) held_raw = word;
      sent += run_len;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    push              = 1'b0;
    in_raw_scan       = '0;
    in_now_ms         = '0;
    cfg_valid         = 1'b0;
    cfg_long_press_ms = '0;
    calm              = 1'b0;
    thr               = {16'h0, LONG_PRESS_RST};
    held_raw          = KEYS_IDLE;
    press_ms          = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every key down, preset press timed just before the counter wraps
    for (int k = 0; k < 8; k++) send_scan('0, 32'hFFFF_FFF8 + k);
    // every key up, duration across the wrap lands exactly on the threshold
    for (int k = 0; k < 8; k++) send_scan('1, (k == 7) ? 32'd399 : k);
    // ring never settles, keys hold
    send_scan(32'hAAAA_AAAA, 32'h0);
    send_scan(32'h5555_5555, 32'hFFFF_FFFF);
    send_scan(32'h0000_0001, 32'h8000_0000);
    send_scan(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    press_ms = 32'hFFFF_FFFF;

    write_threshold(16'd0);
    play_phase(140);
    write_threshold(16'hFFFF);
    play_phase(160);
    write_threshold(16'($urandom_range(1, 60)));
    play_phase(180);
    write_threshold(16'($urandom_range(61, 3000)));
    calm = 1'b1;
    play_phase(200);

    // drain and let the pipeline settle
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
